@@ rtl/tte_pkg.sv @@
`default_nettype none
package tte_pkg;

    typedef struct packed {
        logic               home_set;
        logic               tracking_started;
        logic [15:0]        distance_m;
        logic signed [15:0] height_m;
        logic [15:0]        heading_tenths;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } out_t;

    localparam logic [7:0] CH_D     = 8'd68;
    localparam logic [7:0] CH_H     = 8'd72;
    localparam logic [7:0] CH_A     = 8'd65;
    localparam logic [7:0] CH_HASH  = 8'd35;
    localparam logic [7:0] CH_X     = 8'd88;
    localparam logic [7:0] CH_STAR  = 8'd42;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_NL    = 8'd10;
    localparam logic [3:0] CH_DIGIT_HI = 4'h3;

    // x / 10 == (x * 52429) >> 19, exact for every 16-bit x
    localparam logic [15:0] DIV10_MUL   = 16'd52429;
    localparam int          DIV10_SHIFT = 19;
    localparam logic [15:0] HEAD_MAX    = 16'd3599;

    localparam int DIG_DEPTH = 5;

    typedef enum logic [1:0] {
        SRC_DIST,
        SRC_HMAG,
        SRC_AZ,
        SRC_SUM
    } src_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_HASH,
        ST_X,
        ST_D,
        ST_CONV_DIST,
        ST_EMIT_DIST,
        ST_H,
        ST_MINUS,
        ST_CONV_H,
        ST_EMIT_H,
        ST_A,
        ST_CONV_A,
        ST_EMIT_A,
        ST_STAR,
        ST_CONV_SUM,
        ST_EMIT_SUM,
        ST_NL
    } state_t;

    typedef struct packed {
        logic       capture;
        logic       emit;
        logic       emit_digit;
        logic [7:0] emit_char;
        logic       emit_last;
        logic       sum_clr;
        logic       sum_add;
        logic       conv_load;
        src_t       conv_src;
        logic       conv_step;
    } cmd_t;

    typedef struct packed {
        logic in_home;
        logic in_trk;
        logic out_free;
        logic neg;
        logic conv_last;
        logic dig_one;
    } sts_t;

endpackage
`default_nettype wire

@@ rtl/tte_datapath.sv @@
`default_nettype none
module tte_datapath (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire tte_pkg::in_t  s_data,
    input  wire tte_pkg::cmd_t cmd,
    output tte_pkg::sts_t      sts,
    output logic               m_valid,
    input  wire logic          m_ready,
    output tte_pkg::out_t      m_data
);

    localparam int DCNT_W = $clog2(tte_pkg::DIG_DEPTH + 1);

    logic [15:0] dist_reg, hgt_reg, head_reg;
    logic [15:0] v_reg, v_next;
    logic [7:0]  sum_reg, sum_next;
    logic [3:0]  dig_reg [tte_pkg::DIG_DEPTH];
    logic [3:0]  dig_next [tte_pkg::DIG_DEPTH];
    logic [DCNT_W-1:0] dcnt_reg, dcnt_next;
    logic        m_valid_reg, m_valid_next;
    tte_pkg::out_t m_data_reg;

    logic [31:0] prod;
    logic [12:0] quo;
    logic [15:0] quo10, rem16;
    logic [11:0] head_c;
    logic [27:0] az_prod;
    logic [8:0]  az;
    logic [15:0] hmag;
    logic [15:0] load_val;
    logic [7:0]  byte_out;

    // one decimal digit per step, least significant first
    assign prod  = 32'(v_reg) * 32'(tte_pkg::DIV10_MUL);
    assign quo   = prod[31:tte_pkg::DIV10_SHIFT];
    assign quo10 = {quo, 3'b000} + {2'b00, quo, 1'b0};
    assign rem16 = v_reg - quo10;

    assign head_c  = (head_reg > tte_pkg::HEAD_MAX) ? tte_pkg::HEAD_MAX[11:0] : head_reg[11:0];
    assign az_prod = 28'(head_c) * 28'(tte_pkg::DIV10_MUL);
    assign az      = az_prod[27:tte_pkg::DIV10_SHIFT];
    assign hmag    = hgt_reg[15] ? 16'(~hgt_reg + 16'd1) : hgt_reg;

    always_comb begin
        unique case (cmd.conv_src)
            tte_pkg::SRC_DIST: load_val = dist_reg;
            tte_pkg::SRC_HMAG: load_val = hmag;
            tte_pkg::SRC_AZ:   load_val = {7'd0, az};
            tte_pkg::SRC_SUM:  load_val = {8'd0, sum_reg};
            default:           load_val = dist_reg;
        endcase
    end

    assign byte_out = cmd.emit_digit ? {tte_pkg::CH_DIGIT_HI, dig_reg[0]} : cmd.emit_char;

    always_comb begin
        v_next    = v_reg;
        dcnt_next = dcnt_reg;
        for (int i = 0; i < tte_pkg::DIG_DEPTH; i++) begin
            dig_next[i] = dig_reg[i];
        end
        if (cmd.conv_load) begin
            v_next = load_val;
        end else if (cmd.conv_step) begin
            // push: newest (more significant) digit sits on top
            v_next      = {3'd0, quo};
            dig_next[0] = rem16[3:0];
            for (int i = 1; i < tte_pkg::DIG_DEPTH; i++) begin
                dig_next[i] = dig_reg[i-1];
            end
            dcnt_next = dcnt_reg + DCNT_W'(1);
        end
        if (cmd.emit && cmd.emit_digit) begin
            for (int i = 0; i < tte_pkg::DIG_DEPTH - 1; i++) begin
                dig_next[i] = dig_reg[i+1];
            end
            dcnt_next = dcnt_reg - DCNT_W'(1);
        end
    end

    always_comb begin
        sum_next = sum_reg;
        if (cmd.emit && cmd.sum_clr) begin
            sum_next = byte_out;
        end else if (cmd.emit && cmd.sum_add) begin
            sum_next = sum_reg + byte_out;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            dcnt_reg    <= '0;
        end else begin
            m_valid_reg <= m_valid_next;
            dcnt_reg    <= dcnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            dist_reg <= s_data.distance_m;
            hgt_reg  <= s_data.height_m;
            head_reg <= s_data.heading_tenths;
        end
        if (cmd.emit) begin
            m_data_reg.out_byte <= byte_out;
            m_data_reg.last     <= cmd.emit_last;
        end
        v_reg   <= v_next;
        sum_reg <= sum_next;
        for (int i = 0; i < tte_pkg::DIG_DEPTH; i++) begin
            dig_reg[i] <= dig_next[i];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign sts.in_home   = s_data.home_set;
    assign sts.in_trk    = s_data.tracking_started;
    assign sts.out_free  = !m_valid_reg || m_ready;
    assign sts.neg       = hgt_reg[15];
    assign sts.conv_last = (quo == 13'd0);
    assign sts.dig_one   = (dcnt_reg == DCNT_W'(1));

endmodule
`default_nettype wire

@@ rtl/tte_ctrl.sv @@
`default_nettype none
module tte_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire tte_pkg::sts_t sts,
    output tte_pkg::cmd_t      cmd
);

    tte_pkg::state_t state_reg, state_next;
    logic fix_reg, fix_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tte_pkg::ST_IDLE;
            fix_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            fix_reg   <= fix_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        fix_next      = fix_reg;
        s_ready       = 1'b0;
        cmd           = '0;
        cmd.conv_src  = tte_pkg::SRC_DIST;
        unique case (state_reg)
            tte_pkg::ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
                if (s_valid) begin
                    if (!sts.in_home && !sts.in_trk) begin
                        fix_next   = 1'b0;
                        state_next = tte_pkg::ST_HASH;
                    end else if (sts.in_home && !sts.in_trk && !fix_reg) begin
                        fix_next   = 1'b1;
                        state_next = tte_pkg::ST_X;
                    end else if (fix_reg) begin
                        state_next = tte_pkg::ST_D;
                    end
                end
            end
            tte_pkg::ST_HASH: begin
                cmd.emit_char = tte_pkg::CH_HASH;
                cmd.emit_last = 1'b1;
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = tte_pkg::ST_IDLE;
                end
            end
            tte_pkg::ST_X: begin
                cmd.emit_char = tte_pkg::CH_X;
                cmd.emit_last = 1'b1;
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = tte_pkg::ST_IDLE;
                end
            end
            tte_pkg::ST_D: begin
                cmd.emit_char = tte_pkg::CH_D;
                cmd.sum_clr   = 1'b1;
                cmd.conv_src  = tte_pkg::SRC_DIST;
                if (sts.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.conv_load = 1'b1;
                    state_next    = tte_pkg::ST_CONV_DIST;
                end
            end
            tte_pkg::ST_CONV_DIST: begin
                cmd.conv_step = 1'b1;
                if (sts.conv_last) begin
                    state_next = tte_pkg::ST_EMIT_DIST;
                end
            end
            tte_pkg::ST_EMIT_DIST: begin
                cmd.emit_digit = 1'b1;
                cmd.sum_add    = 1'b1;
                if (sts.out_free) begin
                    cmd.emit = 1'b1;
                    if (sts.dig_one) begin
                        state_next = tte_pkg::ST_H;
                    end
                end
            end
            tte_pkg::ST_H: begin
                cmd.emit_char = tte_pkg::CH_H;
                cmd.sum_add   = 1'b1;
                cmd.conv_src  = tte_pkg::SRC_HMAG;
                if (sts.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.conv_load = 1'b1;
                    state_next    = sts.neg ? tte_pkg::ST_MINUS : tte_pkg::ST_CONV_H;
                end
            end
            tte_pkg::ST_MINUS: begin
                cmd.emit_char = tte_pkg::CH_MINUS;
                cmd.sum_add   = 1'b1;
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = tte_pkg::ST_CONV_H;
                end
            end
            tte_pkg::ST_CONV_H: begin
                cmd.conv_step = 1'b1;
                if (sts.conv_last) begin
                    state_next = tte_pkg::ST_EMIT_H;
                end
            end
            tte_pkg::ST_EMIT_H: begin
                cmd.emit_digit = 1'b1;
                cmd.sum_add    = 1'b1;
                if (sts.out_free) begin
                    cmd.emit = 1'b1;
                    if (sts.dig_one) begin
                        state_next = tte_pkg::ST_A;
                    end
                end
            end
            tte_pkg::ST_A: begin
                cmd.emit_char = tte_pkg::CH_A;
                cmd.sum_add   = 1'b1;
                cmd.conv_src  = tte_pkg::SRC_AZ;
                if (sts.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.conv_load = 1'b1;
                    state_next    = tte_pkg::ST_CONV_A;
                end
            end
            tte_pkg::ST_CONV_A: begin
                cmd.conv_step = 1'b1;
                if (sts.conv_last) begin
                    state_next = tte_pkg::ST_EMIT_A;
                end
            end
            tte_pkg::ST_EMIT_A: begin
                cmd.emit_digit = 1'b1;
                cmd.sum_add    = 1'b1;
                if (sts.out_free) begin
                    cmd.emit = 1'b1;
                    if (sts.dig_one) begin
                        state_next = tte_pkg::ST_STAR;
                    end
                end
            end
            tte_pkg::ST_STAR: begin
                // checksum is final here; '*' itself is not summed
                cmd.emit_char = tte_pkg::CH_STAR;
                cmd.conv_src  = tte_pkg::SRC_SUM;
                if (sts.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.conv_load = 1'b1;
                    state_next    = tte_pkg::ST_CONV_SUM;
                end
            end
            tte_pkg::ST_CONV_SUM: begin
                cmd.conv_step = 1'b1;
                if (sts.conv_last) begin
                    state_next = tte_pkg::ST_EMIT_SUM;
                end
            end
            tte_pkg::ST_EMIT_SUM: begin
                cmd.emit_digit = 1'b1;
                if (sts.out_free) begin
                    cmd.emit = 1'b1;
                    if (sts.dig_one) begin
                        state_next = tte_pkg::ST_NL;
                    end
                end
            end
            tte_pkg::ST_NL: begin
                cmd.emit_char = tte_pkg::CH_NL;
                cmd.emit_last = 1'b1;
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = tte_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tte_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ rtl/tracker_telemetry_frame_encoder.sv @@
`default_nettype none
// '#' or 'X' is registered on m_data from its output state after the word is
// accepted, once the output is free; the next word is taken back in idle.
// A frame converts each number one divide-by-ten step a cycle and then emits its
// digits and marks, up to 22 bytes; the next word is taken only after the newline.
// An m_ready stall on an emitted byte holds the sequence.
// aresetn (synchronous, active low) clears the fix flag, the state, m_valid and the digit count.
module tracker_telemetry_frame_encoder (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire tte_pkg::in_t  s_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output tte_pkg::out_t      m_data
);

    tte_pkg::cmd_t ctl_cmd;
    tte_pkg::sts_t dp_sts;

    // Controller: decides '#', 'X', frame or no output per word, holds the fix flag,
    // and sequences D / H / '-' / A / '*' / newline and the digit groups.
    tte_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (dp_sts),
        .cmd     (ctl_cmd)
    );

    // Datapath: field capture, decimal converter (reciprocal multiply),
    // digit stack, running checksum and the output word register.
    tte_datapath u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (ctl_cmd),
        .sts     (dp_sts),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
`default_nettype wire
